// File: design/tpt_pkg.sv
// Shared constants, codes and types of the timeline playhead transport.
`timescale 1ns / 1ps
`default_nettype none
package tpt_pkg;

   // field widths
   localparam int TIME_W         = 32;
   localparam int DELTA_W        = 20;
   localparam int RATE_W         = 16;
   localparam int RATE_FRAC_BITS = 8;
   localparam int REQ_W          = 3;
   localparam int STATE_W        = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;

   // derived datapath widths
   localparam int PROD_W = DELTA_W + RATE_W;
   localparam int STEP_W = PROD_W - RATE_FRAC_BITS;
   localparam int NT_W   = TIME_W + 1;
   localparam int ADD_W  = NT_W + 1;
   localparam int CNT_W  = $clog2(NT_W + 1);

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PAUSE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SEEK  = 3'd4;

   // transport states
   localparam logic [STATE_W-1:0] PS_STOPPED = 2'd0;
   localparam logic [STATE_W-1:0] PS_PLAYING = 2'd1;
   localparam logic [STATE_W-1:0] PS_PAUSED  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_RATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ASSET_PRES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ASSET_LOOPS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_LOOP_OVR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_OVR     = 3'd5;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

   // arithmetic unit operations
   localparam logic MDU_MUL = 1'b0;
   localparam logic MDU_MOD = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } mdu_cmd_type;

   typedef struct packed {
      logic               done;
      logic [PROD_W-1:0]  product;
      logic [TIME_W-1:0]  remainder;
   } mdu_sts_type;

endpackage
`default_nettype wire

// File: design/tpt_if.sv
// Request and response channel interfaces of the playhead transport.
`timescale 1ns / 1ps
`default_nettype none
interface tpt_req_if;
   logic                              valid;
   logic                              ready;
   logic [tpt_pkg::REQ_W-1:0]         req_type;
   logic [tpt_pkg::DELTA_W-1:0]       tick_delta;
   logic signed [tpt_pkg::TIME_W-1:0] seek_time;

   modport source (output valid, req_type, tick_delta, seek_time, input ready);
   modport sink (input valid, req_type, tick_delta, seek_time, output ready);
endinterface

interface tpt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpt_pkg::STATE_W-1:0]   play_state;
   logic [tpt_pkg::TIME_W-1:0]    playhead;
   logic                          finished;
   logic                          window_valid;
   logic [tpt_pkg::TIME_W-1:0]    window_from;
   logic [tpt_pkg::TIME_W-1:0]    window_to;
   logic                          window_forward;
   logic                          window_wrapped;
   logic                          window_include_from;

   modport source (output valid, play_state, playhead, finished, window_valid,
                   window_from, window_to, window_forward, window_wrapped,
                   window_include_from, input ready);
   modport sink (input valid, play_state, playhead, finished, window_valid,
                 window_from, window_to, window_forward, window_wrapped,
                 window_include_from, output ready);
endinterface
`default_nettype wire

// File: design/tpt_mdu.sv
// Iterative shift-add multiplier and restoring modulo unit on one shared adder.
`timescale 1ns / 1ps
`default_nettype none
module tpt_mdu (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tpt_pkg::mdu_cmd_type          cmd,
   input  wire logic [tpt_pkg::DELTA_W-1:0]   mul_a,
   input  wire logic [tpt_pkg::RATE_W-1:0]    mul_b,
   input  wire logic [tpt_pkg::NT_W-1:0]      dividend,
   input  wire logic [tpt_pkg::TIME_W-1:0]    divisor,
   output tpt_pkg::mdu_sts_type               sts
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          op_ff, op_in;
   logic [tpt_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [tpt_pkg::NT_W-1:0]      acc_ff, acc_in;
   logic [tpt_pkg::NT_W-1:0]      sh_ff, sh_in;
   logic [tpt_pkg::TIME_W-1:0]    opnd_ff, opnd_in;

   logic [tpt_pkg::NT_W-1:0]      shifted;
   logic [tpt_pkg::ADD_W-1:0]     op_a, op_b;
   logic                          cin;
   logic [tpt_pkg::ADD_W:0]       sum;
   logic                          no_borrow;

   // remainder step: bring in next dividend bit, then trial subtract
   assign shifted = {acc_ff[tpt_pkg::TIME_W-1:0], sh_ff[tpt_pkg::NT_W-1]};

   always_comb begin
      if (op_ff == tpt_pkg::MDU_MUL) begin
         op_a = tpt_pkg::ADD_W'(acc_ff);
         op_b = sh_ff[0] ? tpt_pkg::ADD_W'(opnd_ff) : '0;
         cin  = 1'b0;
      end else begin
         op_a = tpt_pkg::ADD_W'(shifted);
         op_b = ~tpt_pkg::ADD_W'(opnd_ff);
         cin  = 1'b1;
      end
   end

   assign sum       = {1'b0, op_a} + {1'b0, op_b} + (tpt_pkg::ADD_W + 1)'(cin);
   assign no_borrow = sum[tpt_pkg::ADD_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opnd_in = opnd_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         acc_in  = '0;
         if (cmd.op == tpt_pkg::MDU_MUL) begin
            cnt_in  = tpt_pkg::CNT_W'(tpt_pkg::RATE_W);
            opnd_in = tpt_pkg::TIME_W'(mul_a);
            sh_in   = tpt_pkg::NT_W'(mul_b);
         end else begin
            cnt_in  = tpt_pkg::CNT_W'(tpt_pkg::NT_W);
            opnd_in = divisor;
            sh_in   = dividend;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tpt_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == tpt_pkg::MDU_MUL) begin
            acc_in = sum[tpt_pkg::ADD_W-1:1];
            sh_in  = tpt_pkg::NT_W'({sum[0], sh_ff[tpt_pkg::RATE_W-1:1]});
         end else begin
            acc_in = no_borrow ? tpt_pkg::NT_W'(sum[tpt_pkg::TIME_W-1:0])
                               : tpt_pkg::NT_W'(shifted[tpt_pkg::TIME_W-1:0]);
            sh_in  = {sh_ff[tpt_pkg::NT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      opnd_ff <= opnd_in;
   end

   assign sts.done      = done_ff;
   assign sts.product   = {acc_ff[tpt_pkg::DELTA_W-1:0], sh_ff[tpt_pkg::RATE_W-1:0]};
   assign sts.remainder = acc_ff[tpt_pkg::TIME_W-1:0];

endmodule
`default_nettype wire

// File: design/timeline_playhead_transport.sv
// A word that does not move the playhead goes from accept through the execute state to the
// response register; a moving tick also runs a 16-step shift-add multiply of delta by rate,
// and a wrapping tick then adds a 33-step restoring modulo by the duration.
// Input is ready again as the response loads: a word is taken only once the last one's response
// has loaded, and a held response stalls the next word in the output stage.
// Synchronous active-high reset: stopped, playhead 0, include-start set, rate 1.0.
`timescale 1ns / 1ps
`default_nettype none
module timeline_playhead_transport (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tpt_req_if.sink                                req_if,
   tpt_rsp_if.source                              rsp_if,
   input  wire logic                              csr_wr_en,
   input  wire logic [tpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tpt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_STEP = 3'd3;
   localparam logic [2:0] S_MOD  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // configuration
   logic [tpt_pkg::RATE_W-1:0]  rate_ff;
   logic [tpt_pkg::TIME_W-1:0]  seq_dur_ff;
   logic                        present_ff, loops_ff, use_ovr_ff, ovr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= tpt_pkg::RATE_RESET;
         seq_dur_ff <= '0;
         present_ff <= 1'b0;
         loops_ff   <= 1'b0;
         use_ovr_ff <= 1'b0;
         ovr_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tpt_pkg::CSR_PLAY_RATE:    rate_ff    <= csr_wdata[tpt_pkg::RATE_W-1:0];
            tpt_pkg::CSR_DURATION:     seq_dur_ff <= csr_wdata[tpt_pkg::TIME_W-1:0];
            tpt_pkg::CSR_ASSET_PRES:   present_ff <= csr_wdata[0];
            tpt_pkg::CSR_ASSET_LOOPS:  loops_ff   <= csr_wdata[0];
            tpt_pkg::CSR_USE_LOOP_OVR: use_ovr_ff <= csr_wdata[0];
            tpt_pkg::CSR_LOOP_OVR:     ovr_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [tpt_pkg::TIME_W-1:0]  dur;
   logic                        looping, rate_neg, rate_zero;
   logic [tpt_pkg::RATE_W-1:0]  rate_mag;

   assign dur       = present_ff ? seq_dur_ff : '0;
   assign looping   = use_ovr_ff ? ovr_ff : (present_ff & loops_ff);
   assign rate_neg  = rate_ff[tpt_pkg::RATE_W-1];
   assign rate_zero = (rate_ff == '0);
   assign rate_mag  = rate_neg ? (tpt_pkg::RATE_W'(0) - rate_ff) : rate_ff;

   // control and transport state
   logic [2:0]                     seq_ff, seq_in;
   logic [tpt_pkg::STATE_W-1:0]    ps_ff, ps_in;
   logic [tpt_pkg::TIME_W-1:0]     ph_ff, ph_in;
   logic                           incl_ff, incl_in;

   // latched word and per-word flags
   logic [tpt_pkg::REQ_W-1:0]      rtype_ff, rtype_in;
   logic [tpt_pkg::DELTA_W-1:0]    delta_ff, delta_in;
   logic [tpt_pkg::TIME_W-1:0]     seek_ff, seek_in;
   logic [tpt_pkg::TIME_W-1:0]     from_ff, from_in;
   logic                           fin_ff, fin_in;
   logic                           wvalid_ff, wvalid_in;
   logic                           wrap_ff, wrap_in;
   logic                           wincl_ff, wincl_in;

   // response register
   logic                           rv_ff, rv_in;
   logic [tpt_pkg::STATE_W-1:0]    o_state_ff, o_state_in;
   logic [tpt_pkg::TIME_W-1:0]     o_ph_ff, o_ph_in;
   logic                           o_fin_ff, o_fin_in;
   logic                           o_wv_ff, o_wv_in;
   logic [tpt_pkg::TIME_W-1:0]     o_from_ff, o_from_in;
   logic [tpt_pkg::TIME_W-1:0]     o_to_ff, o_to_in;
   logic                           o_fwd_ff, o_fwd_in;
   logic                           o_wrap_ff, o_wrap_in;
   logic                           o_incl_ff, o_incl_in;

   tpt_pkg::mdu_cmd_type           mdu_cmd;
   tpt_pkg::mdu_sts_type           mdu_sts;
   logic [tpt_pkg::NT_W-1:0]       mdu_dividend;

   logic [tpt_pkg::STEP_W-1:0]     step;
   logic [tpt_pkg::NT_W-1:0]       fwd_nt, under, dur_ext;
   logic                           step_ge_prev;
   logic                           moving;

   assign step         = mdu_sts.product[tpt_pkg::PROD_W-1:tpt_pkg::RATE_FRAC_BITS];
   assign dur_ext      = tpt_pkg::NT_W'(dur);
   assign fwd_nt       = tpt_pkg::NT_W'(from_ff) + tpt_pkg::NT_W'(step);
   assign under        = tpt_pkg::NT_W'(step) - tpt_pkg::NT_W'(from_ff);
   assign step_ge_prev = (tpt_pkg::NT_W'(step) >= tpt_pkg::NT_W'(from_ff));
   assign moving       = (ps_ff == tpt_pkg::PS_PLAYING) && present_ff && (dur != '0);

   always_comb begin
      seq_in       = seq_ff;
      ps_in        = ps_ff;
      ph_in        = ph_ff;
      incl_in      = incl_ff;
      rtype_in     = rtype_ff;
      delta_in     = delta_ff;
      seek_in      = seek_ff;
      from_in      = from_ff;
      fin_in       = fin_ff;
      wvalid_in    = wvalid_ff;
      wrap_in      = wrap_ff;
      wincl_in     = wincl_ff;
      mdu_cmd      = '0;
      mdu_dividend = fwd_nt;
      rv_in        = rv_ff & ~rsp_if.ready;
      o_state_in   = o_state_ff;
      o_ph_in      = o_ph_ff;
      o_fin_in     = o_fin_ff;
      o_wv_in      = o_wv_ff;
      o_from_in    = o_from_ff;
      o_to_in      = o_to_ff;
      o_fwd_in     = o_fwd_ff;
      o_wrap_in    = o_wrap_ff;
      o_incl_in    = o_incl_ff;

      case (seq_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               rtype_in = req_if.req_type;
               delta_in = req_if.tick_delta;
               seek_in  = req_if.seek_time;
               seq_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            fin_in    = 1'b0;
            wvalid_in = 1'b0;
            wrap_in   = 1'b0;
            wincl_in  = 1'b0;
            from_in   = ph_ff;
            seq_in    = S_OUT;
            case (rtype_ff)
               tpt_pkg::REQ_TICK: begin
                  if (moving) begin
                     mdu_cmd.start = 1'b1;
                     mdu_cmd.op    = tpt_pkg::MDU_MUL;
                     seq_in        = S_MUL;
                  end
               end
               tpt_pkg::REQ_PLAY: begin
                  if (present_ff) begin
                     if (ps_ff == tpt_pkg::PS_STOPPED) begin
                        // rewind a playhead left at the end it runs toward
                        if (!rate_neg && ph_ff >= dur)
                           ph_in = '0;
                        else if (rate_neg && ph_ff == '0)
                           ph_in = dur;
                     end
                     incl_in = 1'b1;
                     ps_in   = tpt_pkg::PS_PLAYING;
                  end
               end
               tpt_pkg::REQ_PAUSE: begin
                  if (ps_ff == tpt_pkg::PS_PLAYING)
                     ps_in = tpt_pkg::PS_PAUSED;
               end
               tpt_pkg::REQ_STOP: begin
                  ps_in   = tpt_pkg::PS_STOPPED;
                  ph_in   = '0;
                  incl_in = 1'b1;
               end
               tpt_pkg::REQ_SEEK: begin
                  if (seek_ff[tpt_pkg::TIME_W-1])
                     ph_in = '0;
                  else if (seek_ff > dur)
                     ph_in = dur;
                  else
                     ph_in = seek_ff;
                  incl_in = 1'b1;
               end
               default: ;
            endcase
         end
         S_MUL: begin
            if (mdu_sts.done)
               seq_in = S_STEP;
         end
         S_STEP: begin
            seq_in = S_OUT;
            if (!rate_zero) begin
               wvalid_in = 1'b1;
               wincl_in  = incl_ff;
               incl_in   = 1'b0;
            end
            if (!rate_neg) begin
               if (fwd_nt >= dur_ext) begin
                  if (looping) begin
                     mdu_cmd.start = 1'b1;
                     mdu_cmd.op    = tpt_pkg::MDU_MOD;
                     mdu_dividend  = fwd_nt;
                     wrap_in       = 1'b1;
                     seq_in        = S_MOD;
                  end else begin
                     ph_in  = dur;
                     ps_in  = tpt_pkg::PS_STOPPED;
                     fin_in = 1'b1;
                  end
               end else begin
                  ph_in = fwd_nt[tpt_pkg::TIME_W-1:0];
               end
            end else if (step_ge_prev) begin
               if (looping) begin
                  if (under != '0) begin
                     mdu_cmd.start = 1'b1;
                     mdu_cmd.op    = tpt_pkg::MDU_MOD;
                     mdu_dividend  = under;
                     wrap_in       = 1'b1;
                     seq_in        = S_MOD;
                  end else begin
                     ph_in = '0;
                  end
               end else begin
                  ph_in  = '0;
                  ps_in  = tpt_pkg::PS_STOPPED;
                  fin_in = 1'b1;
               end
            end else begin
               ph_in = from_ff - tpt_pkg::TIME_W'(step);
            end
         end
         S_MOD: begin
            if (mdu_sts.done) begin
               // backward wrap lands at duration minus the overshoot
               if (!rate_neg || mdu_sts.remainder == '0)
                  ph_in = mdu_sts.remainder;
               else
                  ph_in = dur - mdu_sts.remainder;
               seq_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_if.ready) begin
               rv_in      = 1'b1;
               o_state_in = ps_ff;
               o_ph_in    = ph_ff;
               o_fin_in   = fin_ff;
               o_wv_in    = wvalid_ff;
               o_from_in  = wvalid_ff ? from_ff : '0;
               o_to_in    = wvalid_ff ? ph_ff : '0;
               o_fwd_in   = wvalid_ff & ~rate_neg;
               o_wrap_in  = wvalid_ff & wrap_ff;
               o_incl_in  = wvalid_ff & wincl_ff;
               seq_in     = S_IDLE;
            end
         end
         default: seq_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= S_IDLE;
         ps_ff   <= tpt_pkg::PS_STOPPED;
         ph_ff   <= '0;
         incl_ff <= 1'b1;
         rv_ff   <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         ps_ff   <= ps_in;
         ph_ff   <= ph_in;
         incl_ff <= incl_in;
         rv_ff   <= rv_in;
      end
      rtype_ff   <= rtype_in;
      delta_ff   <= delta_in;
      seek_ff    <= seek_in;
      from_ff    <= from_in;
      fin_ff     <= fin_in;
      wvalid_ff  <= wvalid_in;
      wrap_ff    <= wrap_in;
      wincl_ff   <= wincl_in;
      o_state_ff <= o_state_in;
      o_ph_ff    <= o_ph_in;
      o_fin_ff   <= o_fin_in;
      o_wv_ff    <= o_wv_in;
      o_from_ff  <= o_from_in;
      o_to_ff    <= o_to_in;
      o_fwd_ff   <= o_fwd_in;
      o_wrap_ff  <= o_wrap_in;
      o_incl_ff  <= o_incl_in;
   end

   tpt_mdu u_mdu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mdu_cmd),
      .mul_a    (delta_ff),
      .mul_b    (rate_mag),
      .dividend (mdu_dividend),
      .divisor  (dur),
      .sts      (mdu_sts)
   );

   assign req_if.ready               = (seq_ff == S_IDLE);
   assign rsp_if.valid               = rv_ff;
   assign rsp_if.play_state          = o_state_ff;
   assign rsp_if.playhead            = o_ph_ff;
   assign rsp_if.finished            = o_fin_ff;
   assign rsp_if.window_valid        = o_wv_ff;
   assign rsp_if.window_from         = o_from_ff;
   assign rsp_if.window_to           = o_to_ff;
   assign rsp_if.window_forward      = o_fwd_ff;
   assign rsp_if.window_wrapped      = o_wrap_ff;
   assign rsp_if.window_include_from = o_incl_ff;

endmodule
`default_nettype wire
